// File: src/qstok_pkg.sv
// ----------------------------------------------------------------------------
// qstok_pkg
// Shared types, character codes and escape translation for the quoted-string
// line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qstok_pkg;

  // Source character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  // Translated escape values
  localparam logic [7:0] ESC_BEL = 8'h07;
  localparam logic [7:0] ESC_BS  = 8'h08;
  localparam logic [7:0] ESC_HT  = 8'h09;
  localparam logic [7:0] ESC_LF  = 8'h0A;
  localparam logic [7:0] ESC_VT  = 8'h0B;
  localparam logic [7:0] ESC_FF  = 8'h0C;
  localparam logic [7:0] ESC_CR  = 8'h0D;
  localparam logic [7:0] ESC_ESC = 8'h1B;
  localparam logic [7:0] ESC_NUL = 8'h00;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_ESCAPE = 2'd1,
    STAT_LONE_BSL   = 2'd2,
    STAT_OPEN_STR   = 2'd3
  } status_t;

  // Tokenizer flags carried from item to item
  typedef struct packed {
    logic inside_string;
    logic escape_pending;
    logic token_open;
    logic discard_rest;
  } tok_state_t;

  // One result item
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       token_end;
    status_t    status;
  } tok_result_t;

  // Escape lookup result
  typedef struct packed {
    logic       ok;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t escape_lookup(input logic [7:0] c);
    esc_t r;
    r.ok   = 1'b1;
    r.code = ESC_NUL;
    case (c)
      CH_BSLASH: r.code = CH_BSLASH;
      CH_QUOTE:  r.code = CH_QUOTE;
      CH_LC_A:   r.code = ESC_BEL;
      CH_LC_B:   r.code = ESC_BS;
      CH_LC_T:   r.code = ESC_HT;
      CH_LC_N:   r.code = ESC_LF;
      CH_LC_V:   r.code = ESC_VT;
      CH_LC_F:   r.code = ESC_FF;
      CH_LC_R:   r.code = ESC_CR;
      CH_LC_E:   r.code = ESC_ESC;
      CH_ZERO:   r.code = ESC_NUL;
      default:   r.ok   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/qstok_core.sv
// ----------------------------------------------------------------------------
// qstok_core
// Combinational step of the tokenizer: one character and the current flags
// in, the next flags and one result item out.
// ----------------------------------------------------------------------------
`default_nettype none

module qstok_core (
  input  wire logic [7:0]              ch,
  input  wire logic                    line_end,
  input  wire qstok_pkg::tok_state_t   state_cur,
  output qstok_pkg::tok_state_t        state_nxt,
  output qstok_pkg::tok_result_t       result
);

  qstok_pkg::esc_t esc;

  assign esc = qstok_pkg::escape_lookup(ch);

  always_comb begin
    qstok_pkg::tok_state_t s;
    logic                  hc;
    logic [7:0]            oc;
    logic                  te;
    qstok_pkg::status_t    stat;

    s    = state_cur;
    hc   = 1'b0;
    oc   = 8'h00;
    te   = 1'b0;
    stat = qstok_pkg::STAT_OK;

    // Character classification
    if (s.discard_rest) begin
      // rest of line ignored
    end else if (s.escape_pending) begin
      s.escape_pending = 1'b0;
      if (esc.ok) begin
        hc           = 1'b1;
        oc           = esc.code;
        s.token_open = 1'b1;
      end else begin
        stat           = qstok_pkg::STAT_BAD_ESCAPE;
        s.discard_rest = 1'b1;
      end
    end else if (ch == qstok_pkg::CH_SPACE) begin
      if (s.inside_string) begin
        hc           = 1'b1;
        oc           = ch;
        s.token_open = 1'b1;
      end else begin
        te           = s.token_open;
        s.token_open = 1'b0;
      end
    end else if (ch == qstok_pkg::CH_QUOTE) begin
      s.inside_string = ~s.inside_string;
      hc              = 1'b1;
      oc              = ch;
      s.token_open    = 1'b1;
    end else if (ch == qstok_pkg::CH_BSLASH) begin
      if (line_end) begin
        stat           = qstok_pkg::STAT_LONE_BSL;
        s.discard_rest = 1'b1;
      end else begin
        s.escape_pending = 1'b1;
      end
    end else if (ch == qstok_pkg::CH_HASH) begin
      if (s.inside_string) begin
        hc           = 1'b1;
        oc           = ch;
        s.token_open = 1'b1;
      end else begin
        te             = s.token_open;
        s.token_open   = 1'b0;
        s.discard_rest = 1'b1;
      end
    end else begin
      hc           = 1'b1;
      oc           = ch;
      s.token_open = 1'b1;
    end

    // Line end closes the token or flags an open string
    if (line_end && !s.discard_rest && !s.escape_pending) begin
      if (s.inside_string) begin
        stat = qstok_pkg::STAT_OPEN_STR;
      end else if (s.token_open) begin
        te           = 1'b1;
        s.token_open = 1'b0;
      end
    end

    // Any error drops the token being built
    if (stat != qstok_pkg::STAT_OK) begin
      hc = 1'b0;
      oc = 8'h00;
      te = 1'b0;
    end

    if (line_end) begin
      s = '0;
    end

    state_nxt        = s;
    result.has_char  = hc;
    result.out_char  = oc;
    result.token_end = te;
    result.status    = stat;
  end

endmodule

`default_nettype wire

// File: src/quoted_string_line_tokenizer_unit.sv
// Each character passes through the input register, then the result register, on its
// way to out_*; the result register holds a result until the result stream takes it.
// Throughput: one character per cycle while out_tready does not stall the result stage;
// the input register and the result register form a two-stage pipeline with per-stage
// valid flags.
// Reset (rst_n low, synchronous): both stages empty, tokenizer flags cleared.
// ----------------------------------------------------------------------------
// quoted_string_line_tokenizer_unit
// Splits lines of characters into tokens at spaces outside quoted strings,
// translating backslash escapes and dropping comments.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_line_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic       in_tlast,   // line_end
  // Result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,  // token_end
  output logic [2:0]      out_tuser   // [0] has_char, [2:1] status
);

  logic                    in_vld_r;
  logic [7:0]              in_ch_r;
  logic                    in_le_r;
  qstok_pkg::tok_state_t   state_r;
  qstok_pkg::tok_state_t   state_nxt;
  qstok_pkg::tok_result_t  res_nxt;
  qstok_pkg::tok_result_t  res_r;
  logic                    out_vld_r;
  logic                    out_ready;
  logic                    adv;

  // Stage handshake
  assign out_ready = !out_vld_r || out_tready;
  assign adv       = in_vld_r && out_ready;
  assign in_tready = !in_vld_r || out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r <= in_tdata;
      in_le_r <= in_tlast;
    end
  end

  qstok_core u_core (
    .ch        (in_ch_r),
    .line_end  (in_le_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // Tokenizer flags and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        state_r <= state_nxt;
      end
      if (out_ready) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r.out_char;
  assign out_tlast  = res_r.token_end;
  assign out_tuser  = {res_r.status, res_r.has_char};

endmodule

`default_nettype wire

// File: src/qstok_chk.sv
// ----------------------------------------------------------------------------
// qstok_chk
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qstok_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [2:0] out_tuser
);

  // Pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A pending result is not dropped while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // An error result carries no character and no token end
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != qstok_pkg::STAT_OK) |->
      !out_tuser[0] && !out_tlast && (out_tdata == 8'h00))
    else $error("error result carries data");

  // No character means zero data byte
  a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'h00)
    else $error("data byte set without has_char");

  // With an empty result stage the input side is always open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !$past(in_tvalid && in_tready) |-> in_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind quoted_string_line_tokenizer_unit qstok_chk u_qstok_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: tb/sv/qstok_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qstok_checker
// Passive checker for the tokenizer: it watches both streams, keeps its own
// copy of the tokenizer flags and predicts the result of every accepted
// character. Results are compared field by field, in order, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------

module qstok_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] ch
  input  logic              in_tlast,    // line_end
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,   // [7:0] out_char
  input  logic              out_tlast,   // token_end
  input  logic [2:0]        out_tuser,   // [0] has_char, [2:1] status
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  qstok_pkg::tok_state_t  flags;
  qstok_pkg::tok_result_t predicted_q[$];
  int unsigned            results_seen;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    flags        = '0;
  end

  // Advance the tokenizer flags by one character and return its result
  function automatic qstok_pkg::tok_result_t tokenize_char(input logic [7:0] c,
                                                           input logic       last);
    qstok_pkg::tok_result_t r;
    logic [7:0]             code;
    logic                   known;
    r        = '0;
    r.status = qstok_pkg::STAT_OK;
    code     = qstok_pkg::ESC_NUL;
    known    = 1'b1;
    if (flags.discard_rest) begin
      // rest of line ignored after a comment or an error
    end else if (flags.escape_pending) begin
      flags.escape_pending = 1'b0;
      case (c)
        qstok_pkg::CH_BSLASH, qstok_pkg::CH_QUOTE: code = c;
        qstok_pkg::CH_LC_A: code = qstok_pkg::ESC_BEL;
        qstok_pkg::CH_LC_B: code = qstok_pkg::ESC_BS;
        qstok_pkg::CH_LC_T: code = qstok_pkg::ESC_HT;
        qstok_pkg::CH_LC_N: code = qstok_pkg::ESC_LF;
        qstok_pkg::CH_LC_V: code = qstok_pkg::ESC_VT;
        qstok_pkg::CH_LC_F: code = qstok_pkg::ESC_FF;
        qstok_pkg::CH_LC_R: code = qstok_pkg::ESC_CR;
        qstok_pkg::CH_LC_E: code = qstok_pkg::ESC_ESC;
        qstok_pkg::CH_ZERO: code = qstok_pkg::ESC_NUL;
        default: known = 1'b0;
      endcase
      if (known) begin
        r.has_char       = 1'b1;
        r.out_char       = code;
        flags.token_open = 1'b1;
      end else begin
        r.status           = qstok_pkg::STAT_BAD_ESCAPE;
        flags.discard_rest = 1'b1;
      end
    end else if (c == qstok_pkg::CH_SPACE && !flags.inside_string) begin
      r.token_end      = flags.token_open;
      flags.token_open = 1'b0;
    end else if (c == qstok_pkg::CH_BSLASH) begin
      if (last) begin
        r.status           = qstok_pkg::STAT_LONE_BSL;
        flags.discard_rest = 1'b1;
      end else begin
        flags.escape_pending = 1'b1;
      end
    end else if (c == qstok_pkg::CH_HASH && !flags.inside_string) begin
      // comment: close the open token in the same transfer
      r.token_end        = flags.token_open;
      flags.token_open   = 1'b0;
      flags.discard_rest = 1'b1;
    end else begin
      if (c == qstok_pkg::CH_QUOTE) flags.inside_string = !flags.inside_string;
      r.has_char       = 1'b1;
      r.out_char       = c;
      flags.token_open = 1'b1;
    end

    // line end closes the token or flags an open string
    if (last && !flags.discard_rest && !flags.escape_pending) begin
      if (flags.inside_string) begin
        r.status = qstok_pkg::STAT_OPEN_STR;
      end else if (flags.token_open) begin
        r.token_end = 1'b1;
      end
    end
    if (r.status != qstok_pkg::STAT_OK) begin
      r.has_char  = 1'b0;
      r.out_char  = 8'h00;
      r.token_end = 1'b0;
    end
    if (last) flags = '0;
    return r;
  endfunction

  // Compare result transfers, then record the prediction for a new character
  always @(posedge clk) begin
    qstok_pkg::tok_result_t exp_res;
    if (!rst_n) begin
      flags = '0;
      predicted_q.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen = results_seen + 1;
        if (predicted_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %0d arrived with nothing expected", $realtime, results_seen);
          mismatches <= mismatches + 1;
        end else begin
          exp_res = predicted_q.pop_front();
          if (out_tuser[0] !== exp_res.has_char || out_tdata !== exp_res.out_char ||
              out_tlast !== exp_res.token_end || out_tuser[2:1] !== exp_res.status) begin
            if (mismatches < 10)
              $display({"%0t: result %0d mismatch: has_char %0b/%0b char %02h/%02h ",
                        "token_end %0b/%0b status %0d/%0d (expected/actual)"},
                       $realtime, results_seen, exp_res.has_char, out_tuser[0],
                       exp_res.out_char, out_tdata, exp_res.token_end, out_tlast,
                       exp_res.status, out_tuser[2:1]);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predicted_q.insert(predicted_q.size(), tokenize_char(in_tdata, in_tlast));
      outstanding <= predicted_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quoted-string line tokenizer. Drives a short
// directed set of lines covering comments, escapes, errors and open strings,
// then random lines, with random idle bursts on both streams. Checking is
// done by qstok_checker.
// ----------------------------------------------------------------------------

module tb;

  typedef logic [7:0] char_q_t[$];

  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned RANDOM_CHARS = 850;
  localparam int unsigned QUIET_AFTER  = 720;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned chars_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap_rate = 0;
  logic        quiet       = 1'b0;

  // characters that form a valid escape after a backslash
  logic [7:0] esc_chars [11] = '{qstok_pkg::CH_BSLASH, qstok_pkg::CH_QUOTE,
                                  qstok_pkg::CH_LC_A, qstok_pkg::CH_LC_B,
                                  qstok_pkg::CH_LC_T, qstok_pkg::CH_LC_N,
                                  qstok_pkg::CH_LC_V, qstok_pkg::CH_LC_F,
                                  qstok_pkg::CH_LC_R, qstok_pkg::CH_LC_E,
                                  qstok_pkg::CH_ZERO};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quoted_string_line_tokenizer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  qstok_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side backpressure: ready stretches with random stall bursts
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12))
        @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Send one line; the last character carries the line end flag
  task automatic send_line(input char_q_t line);
    foreach (line[i]) begin
      if (!quiet && in_gap_rate != 0 && $urandom_range(1, 8) <= in_gap_rate) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= line[i];
      in_tlast  <= (i == line.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      chars_sent = chars_sent + 1;
    end
  endtask

  initial begin : stimulus
    string       dir_text [6];
    char_q_t     line;
    logic        open_str;
    int unsigned line_len;
    int unsigned pick;

    // comment cutting a token, bad escape in a string, escape then lone
    // backslash, open string at line end, escaped quote and '#' in a string
    dir_text = '{"ab #x", "\"\\q", "x\\n\\", "\"a b", "\"\\\"#\"", "ab "};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines
    foreach (dir_text[j]) begin
      line.delete();
      for (int k = 0; k < dir_text[j].len(); k++) line.insert(line.size(), dir_text[j][k]);
      in_gap_rate = $urandom_range(0, 3);
      send_line(line);
    end
    // byte extremes, then a trailing space
    in_gap_rate = 2;
    send_line('{8'h00, 8'hFF, qstok_pkg::CH_SPACE});

    // Random lines, mostly well formed with random content
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= QUIET_AFTER) quiet = 1'b1;
      in_gap_rate = $urandom_range(0, 3);
      line.delete();
      open_str = 1'b0;
      line_len = $urandom_range(1, 14);
      while (line.size() < line_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          line.insert(line.size(), 8'($urandom_range(8'h21, 8'h7E)));
        end else if (pick < 55) begin
          line.insert(line.size(), qstok_pkg::CH_SPACE);
        end else if (pick < 63) begin
          line.insert(line.size(), qstok_pkg::CH_QUOTE);
          open_str = !open_str;
        end else if (pick < 75) begin
          line.insert(line.size(), qstok_pkg::CH_BSLASH);
          line.insert(line.size(), $urandom_range(0, 9) == 0 ? 8'($urandom)
                                   : esc_chars[$urandom_range(0, 10)]);
        end else if (pick < 80) begin
          line.insert(line.size(), qstok_pkg::CH_HASH);
        end else if (pick < 84) begin
          // bare backslash: lone at line end, or escapes whatever follows
          line.insert(line.size(), qstok_pkg::CH_BSLASH);
        end else begin
          line.insert(line.size(), 8'($urandom));
        end
      end
      // close most open strings
      if (open_str && $urandom_range(0, 5) != 0) line.insert(line.size(), qstok_pkg::CH_QUOTE);
      send_line(line);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for the two-stage pipeline
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
